FILE: src/ryc_pkg.sv
`default_nettype none
package ryc_pkg;

	// coefficients scaled by 1e5, turned into fixed point at elaboration
	localparam longint E5_KR  = 29900;
	localparam longint E5_KG  = 58700;
	localparam longint E5_KB  = 11400;
	localparam longint E5_KU  = 56400;
	localparam longint E5_KV  = 71300;
	localparam longint E5_KRV = 113983;
	localparam longint E5_KGU = 39465;
	localparam longint E5_KGV = 58060;
	localparam longint E5_KBU = 203211;

	localparam longint COEF_DEN  = 100000;
	localparam longint COEF_HALF = 50000;

	localparam int COMP_W  = 8;
	localparam int TDATA_W = 3 * COMP_W;

	localparam logic MODE_RGB2YUV = 1'b0;
	localparam logic MODE_YUV2RGB = 1'b1;

	// round half up of e5 / 1e5 * 2^frac
	function automatic longint ryc_coef(input longint e5, input int frac);
		return ((e5 <<< frac) + COEF_HALF) / COEF_DEN;
	endfunction

	typedef struct packed {
		logic              valid;
		logic              en;
	} ryc_ctl_t;

	typedef struct packed {
		logic              dir;
		logic              last;
		logic [COMP_W-1:0] a;
		logic [COMP_W-1:0] b;
		logic [COMP_W-1:0] c;
	} ryc_pix_t;

	typedef struct packed {
		logic              dir;
		logic              last;
		logic [COMP_W-1:0] r0;
		logic [COMP_W-1:0] r1;
		logic [COMP_W-1:0] r2;
		logic [COMP_W-1:0] a;
		logic [COMP_W-1:0] c;
	} ryc_mid_t;

	typedef struct packed {
		logic              last;
		logic [COMP_W-1:0] r0;
		logic [COMP_W-1:0] r1;
		logic [COMP_W-1:0] r2;
	} ryc_res_t;

endpackage
`default_nettype wire

FILE: src/ryc_mult_stage.sv
`default_nettype none
module ryc_mult_stage #(
	parameter int FRAC_BITS = 16,
	localparam int PW = FRAC_BITS + 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ryc_pkg::ryc_ctl_t    ctl,
	input  wire ryc_pkg::ryc_pix_t    pix_in,
	output logic                      valid_out,
	output ryc_pkg::ryc_pix_t         pix_out,
	output logic signed [PW-1:0]      prod0,
	output logic signed [PW-1:0]      prod1,
	output logic signed [PW-1:0]      prod2,
	output logic signed [PW-1:0]      prod3
);
	import ryc_pkg::*;

	localparam int CW = FRAC_BITS + 3;
	localparam logic signed [CW-1:0] K_R  = CW'(ryc_coef(E5_KR, FRAC_BITS));
	localparam logic signed [CW-1:0] K_G  = CW'(ryc_coef(E5_KG, FRAC_BITS));
	localparam logic signed [CW-1:0] K_B  = CW'(ryc_coef(E5_KB, FRAC_BITS));
	localparam logic signed [CW-1:0] K_RV = CW'(ryc_coef(E5_KRV, FRAC_BITS));
	localparam logic signed [CW-1:0] K_GU = CW'(ryc_coef(E5_KGU, FRAC_BITS));
	localparam logic signed [CW-1:0] K_GV = CW'(ryc_coef(E5_KGV, FRAC_BITS));
	localparam logic signed [CW-1:0] K_BU = CW'(ryc_coef(E5_KBU, FRAC_BITS));

	logic signed [9:0]    op_a, op_b, op_c, op_u, op_v;
	logic signed [9:0]    op0, op1, op2, op3;
	logic signed [CW-1:0] k0, k1, k2, k3;
	logic signed [PW-1:0] m0, m1, m2, m3;
	logic                 v_s1;
	ryc_pix_t             pix_s1;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1;

	assign op_a = $signed({2'b00, pix_in.a});
	assign op_b = $signed({2'b00, pix_in.b});
	assign op_c = $signed({2'b00, pix_in.c});
	assign op_u = op_b - 10'sd128;
	assign op_v = op_c - 10'sd128;

	// rgb to yuv: luma weights; yuv to rgb: four chroma terms
	always_comb begin
		if (pix_in.dir == MODE_YUV2RGB) begin
			op0 = op_v;  k0 = K_RV;
			op1 = op_u;  k1 = K_GU;
			op2 = op_v;  k2 = K_GV;
			op3 = op_u;  k3 = K_BU;
		end else begin
			op0 = op_a;  k0 = K_R;
			op1 = op_b;  k1 = K_G;
			op2 = op_c;  k2 = K_B;
			op3 = '0;    k3 = '0;
		end
	end

	assign m0 = k0 * op0;
	assign m1 = k1 * op1;
	assign m2 = k2 * op2;
	assign m3 = k3 * op3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.valid) begin
			pix_s1 <= pix_in;
			p0_s1  <= m0;
			p1_s1  <= m1;
			p2_s1  <= m2;
			p3_s1  <= m3;
		end
	end

	assign valid_out = v_s1;
	assign pix_out   = pix_s1;
	assign prod0     = p0_s1;
	assign prod1     = p1_s1;
	assign prod2     = p2_s1;
	assign prod3     = p3_s1;

endmodule
`default_nettype wire

FILE: src/ryc_luma_stage.sv
`default_nettype none
module ryc_luma_stage #(
	parameter int FRAC_BITS = 16,
	localparam int PW = FRAC_BITS + 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ryc_pkg::ryc_ctl_t    ctl,
	input  wire ryc_pkg::ryc_pix_t    pix_in,
	input  wire logic signed [PW-1:0] prod0,
	input  wire logic signed [PW-1:0] prod1,
	input  wire logic signed [PW-1:0] prod2,
	input  wire logic signed [PW-1:0] prod3,
	output logic                      valid_out,
	output ryc_pkg::ryc_mid_t         mid_out
);
	import ryc_pkg::*;

	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] SAT_MAX = SW'(255);

	function automatic logic [COMP_W-1:0] sat8(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] f;
		f = x >>> FRAC_BITS;
		if (f < 0)
			return '0;
		else if (f > SAT_MAX)
			return '1;
		else
			return f[COMP_W-1:0];
	endfunction

	logic signed [SW-1:0] e0, e1, e2, e3, ys;
	logic signed [SW-1:0] sum_y, sum_r, sum_g, sum_b;
	ryc_mid_t             mid_d;
	logic                 v_s2;
	ryc_mid_t             mid_s2;

	assign e0 = {{2{prod0[PW-1]}}, prod0};
	assign e1 = {{2{prod1[PW-1]}}, prod1};
	assign e2 = {{2{prod2[PW-1]}}, prod2};
	assign e3 = {{2{prod3[PW-1]}}, prod3};
	assign ys = $signed({{(SW-COMP_W){1'b0}}, pix_in.a}) <<< FRAC_BITS;

	assign sum_y = e0 + e1 + e2;
	assign sum_r = ys + e0;
	assign sum_g = ys - e1 - e2;
	assign sum_b = ys + e3;

	always_comb begin
		mid_d.dir  = pix_in.dir;
		mid_d.last = pix_in.last;
		mid_d.a    = pix_in.a;
		mid_d.c    = pix_in.c;
		if (pix_in.dir == MODE_YUV2RGB) begin
			mid_d.r0 = sat8(sum_r);
			mid_d.r1 = sat8(sum_g);
			mid_d.r2 = sat8(sum_b);
		end else begin
			// chroma slots filled in later stages
			mid_d.r0 = sat8(sum_y);
			mid_d.r1 = '0;
			mid_d.r2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.en) begin
			v_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.valid) begin
			mid_s2 <= mid_d;
		end
	end

	assign valid_out = v_s2;
	assign mid_out   = mid_s2;

endmodule
`default_nettype wire

FILE: src/ryc_chroma_stage.sv
`default_nettype none
module ryc_chroma_stage #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ryc_pkg::ryc_ctl_t    ctl_mul,
	input  wire ryc_pkg::ryc_ctl_t    ctl_out,
	input  wire ryc_pkg::ryc_mid_t    mid_in,
	output logic                      valid_mul,
	output logic                      valid_out,
	output ryc_pkg::ryc_res_t         res_out
);
	import ryc_pkg::*;

	localparam int CW = FRAC_BITS + 3;
	localparam int PW = CW + 10;
	localparam int SW = PW + 2;
	localparam logic signed [CW-1:0] K_U = CW'(ryc_coef(E5_KU, FRAC_BITS));
	localparam logic signed [CW-1:0] K_V = CW'(ryc_coef(E5_KV, FRAC_BITS));
	localparam logic signed [SW-1:0] OFFSET = SW'(128) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_MAX = SW'(255);

	function automatic logic [COMP_W-1:0] sat8(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] f;
		f = x >>> FRAC_BITS;
		if (f < 0)
			return '0;
		else if (f > SAT_MAX)
			return '1;
		else
			return f[COMP_W-1:0];
	endfunction

	logic signed [9:0]    d_b, d_r;
	logic signed [PW-1:0] m_u, m_v;
	logic                 v_s3, v_s4;
	ryc_mid_t             mid_s3;
	logic signed [PW-1:0] qu_s3, qv_s3;
	logic signed [SW-1:0] sum_u, sum_v;
	ryc_res_t             res_d, res_s4;

	// B - Y and R - Y against the already saturated luma
	assign d_b = $signed({2'b00, mid_in.c}) - $signed({2'b00, mid_in.r0});
	assign d_r = $signed({2'b00, mid_in.a}) - $signed({2'b00, mid_in.r0});
	assign m_u = K_U * d_b;
	assign m_v = K_V * d_r;

	assign sum_u = {{2{qu_s3[PW-1]}}, qu_s3} + OFFSET;
	assign sum_v = {{2{qv_s3[PW-1]}}, qv_s3} + OFFSET;

	always_comb begin
		res_d.last = mid_s3.last;
		res_d.r0   = mid_s3.r0;
		if (mid_s3.dir == MODE_YUV2RGB) begin
			res_d.r1 = mid_s3.r1;
			res_d.r2 = mid_s3.r2;
		end else begin
			res_d.r1 = sat8(sum_u);
			res_d.r2 = sat8(sum_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl_mul.en)
				v_s3 <= ctl_mul.valid;
			if (ctl_out.en)
				v_s4 <= ctl_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_mul.en && ctl_mul.valid) begin
			mid_s3 <= mid_in;
			qu_s3  <= m_u;
			qv_s3  <= m_v;
		end
		if (ctl_out.en && ctl_out.valid) begin
			res_s4 <= res_d;
		end
	end

	assign valid_mul = v_s3;
	assign valid_out = v_s4;
	assign res_out   = res_s4;

endmodule
`default_nettype wire

FILE: src/rgb_yuv_color_converter_core.sv
// throughput: one pixel per cycle while the output is not stalled
// four register stages, multipliers in the first and third
// ready is a combinational chain through the stage valid bits: with every stage full an
// output stall drops input ready in the same cycle, a stage with a bubble keeps accepting
// reset: arst_n clears all stage valid bits and the direction register (rgb to yuv)
// payload registers are not reset
`default_nettype none
module rgb_yuv_color_converter_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// direction register write, always ready
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_data,
	// input pixels
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [ryc_pkg::TDATA_W-1:0]   s_axis_tdata,  // comp_first, comp_second, comp_third
	input  wire logic                          s_axis_tlast,
	// converted pixels
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [ryc_pkg::TDATA_W-1:0]        m_axis_tdata,  // res_first, res_second, res_third
	output logic                               m_axis_tlast
);
	import ryc_pkg::*;

	localparam int PW = FRAC_BITS + 13;

	logic                 dir_q;
	ryc_pix_t             pix_in;
	ryc_pix_t             pix_s1;
	ryc_mid_t             mid_s2;
	ryc_res_t             res_s4;
	logic signed [PW-1:0] p0, p1, p2, p3;
	logic                 v1, v2, v3, v4;
	logic                 en1, en2, en3, en4;
	ryc_ctl_t             ctl1, ctl2, ctl3, ctl4;

	// direction register, to be written only while the pipeline is empty; the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= MODE_RGB2YUV;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= cfg_data;
		end
	end

	// unpack the input beat, direction travels with the pixel
	assign pix_in.dir  = dir_q;
	assign pix_in.last = s_axis_tlast;
	assign pix_in.a    = s_axis_tdata[COMP_W-1:0];
	assign pix_in.b    = s_axis_tdata[2*COMP_W-1:COMP_W];
	assign pix_in.c    = s_axis_tdata[3*COMP_W-1:2*COMP_W];

	// a stage loads when it is empty or its contents move on
	assign en4 = !v4 || m_axis_tready;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;

	assign s_axis_tready = en1;

	assign ctl1 = '{valid: s_axis_tvalid, en: en1};
	assign ctl2 = '{valid: v1, en: en2};
	assign ctl3 = '{valid: v2, en: en3};
	assign ctl4 = '{valid: v3, en: en4};

	// stage 1: luma weights or the four chroma products
	ryc_mult_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl1),
		.pix_in    (pix_in),
		.valid_out (v1),
		.pix_out   (pix_s1),
		.prod0     (p0),
		.prod1     (p1),
		.prod2     (p2),
		.prod3     (p3)
	);

	// stage 2: sums, floor and clamp; luma in one mode, full rgb in the other
	ryc_luma_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl2),
		.pix_in    (pix_s1),
		.prod0     (p0),
		.prod1     (p1),
		.prod2     (p2),
		.prod3     (p3),
		.valid_out (v2),
		.mid_out   (mid_s2)
	);

	// stages 3 and 4: chroma products from the clamped luma, then offset and clamp; yuv to rgb results pass through
	ryc_chroma_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_mul   (ctl3),
		.ctl_out   (ctl4),
		.mid_in    (mid_s2),
		.valid_mul (v3),
		.valid_out (v4),
		.res_out   (res_s4)
	);

	// the last stage is the output register
	assign m_axis_tvalid = v4;
	assign m_axis_tdata  = {res_s4.r2, res_s4.r1, res_s4.r0};
	assign m_axis_tlast  = res_s4.last;

endmodule
`default_nettype wire

FILE: src/ryc_checker.sv
`default_nettype none
module ryc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        cfg_data,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [23:0] s_axis_tdata,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	localparam int DEPTH = 4;

	logic       in_beat, out_beat;
	logic [2:0] count_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// pixels inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_beat && !out_beat) begin
			count_q <= count_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			count_q <= count_q - 3'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input not ready while output register frees");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> count_q != 3'd0)
		else $error("output beat without an input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH))
		else $error("more pixels in flight than pipeline stages");

endmodule

bind rgb_yuv_color_converter_core ryc_checker u_ryc_checker (.*);
`default_nettype wire

FILE: tb/ryc_conv_checker.sv
`timescale 1ns / 100ps
module ryc_conv_checker #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic                        cfg_ready,
	input  wire logic                        cfg_data,
	input  wire logic                        s_axis_tvalid,
	input  wire logic                        s_axis_tready,
	input  wire logic [ryc_pkg::TDATA_W-1:0] s_axis_tdata,  // comp_first, comp_second, comp_third
	input  wire logic                        s_axis_tlast,
	input  wire logic                        m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	input  wire logic [ryc_pkg::TDATA_W-1:0] m_axis_tdata,  // res_first, res_second, res_third
	input  wire logic                        m_axis_tlast,
	output int                               pending_pixels,
	output int                               mismatch_count
);
	import ryc_pkg::*;

	typedef struct {
		logic [COMP_W-1:0] first;
		logic [COMP_W-1:0] second;
		logic [COMP_W-1:0] third;
		logic              last;
	} pixel_beat_t;

	localparam longint ONE  = longint'(1) << FRAC_BITS;
	localparam longint K_RY = (29900 * ONE + 50000) / 100000;
	localparam longint K_GY = (58700 * ONE + 50000) / 100000;
	localparam longint K_BY = (11400 * ONE + 50000) / 100000;
	localparam longint K_U  = (56400 * ONE + 50000) / 100000;
	localparam longint K_V  = (71300 * ONE + 50000) / 100000;
	localparam longint K_RV = (113983 * ONE + 50000) / 100000;
	localparam longint K_GU = (39465 * ONE + 50000) / 100000;
	localparam longint K_GV = (58060 * ONE + 50000) / 100000;
	localparam longint K_BU = (203211 * ONE + 50000) / 100000;

	logic        direction;
	pixel_beat_t converted_q[$];

	function automatic logic [COMP_W-1:0] clamp8(input longint v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return v[COMP_W-1:0];
	endfunction

	// fixed point conversion, arithmetic shift gives the floor
	function automatic pixel_beat_t convert_pixel(input logic dir,
			input logic [TDATA_W-1:0] data, input logic last);
		longint a, b, c, y, u, v, ys;
		longint acc0, acc1, acc2;
		pixel_beat_t p;
		a = data[COMP_W-1:0];
		b = data[2*COMP_W-1:COMP_W];
		c = data[3*COMP_W-1:2*COMP_W];
		if (dir == MODE_RGB2YUV) begin
			y = clamp8((K_RY * a + K_GY * b + K_BY * c) >>> FRAC_BITS);
			acc0 = y;
			acc1 = (K_U * (c - y) + 128 * ONE) >>> FRAC_BITS;
			acc2 = (K_V * (a - y) + 128 * ONE) >>> FRAC_BITS;
		end else begin
			u = b - 128;
			v = c - 128;
			ys = a * ONE;
			acc0 = (ys + K_RV * v) >>> FRAC_BITS;
			acc1 = (ys - K_GU * u - K_GV * v) >>> FRAC_BITS;
			acc2 = (ys + K_BU * u) >>> FRAC_BITS;
		end
		p.first = clamp8(acc0);
		p.second = clamp8(acc1);
		p.third = clamp8(acc2);
		p.last = last;
		return p;
	endfunction

	function automatic int field_differs(input string name, input logic [COMP_W-1:0] want,
			input logic [COMP_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_beat_t want;
		int errs;
		if (!arst_n) begin
			direction <= MODE_RGB2YUV;
			converted_q.delete();
			pending_pixels <= 0;
			mismatch_count <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready)
				direction <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				converted_q.push_back(convert_pixel(direction, s_axis_tdata, s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				if (converted_q.size() == 0) begin
					$display("%0t: output beat with none expected, got data %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					errs++;
				end else begin
					want = converted_q.pop_front();
					errs += field_differs("res_first", want.first, m_axis_tdata[COMP_W-1:0]);
					errs += field_differs("res_second", want.second,
						m_axis_tdata[2*COMP_W-1:COMP_W]);
					errs += field_differs("res_third", want.third,
						m_axis_tdata[3*COMP_W-1:2*COMP_W]);
					errs += field_differs("out_last", {7'd0, want.last}, {7'd0, m_axis_tlast});
				end
			end
			pending_pixels <= converted_q.size();
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

FILE: tb/rgb_yuv_color_converter_core_test.sv
`timescale 1ns / 100ps
module rgb_yuv_color_converter_core_test;
	import ryc_pkg::*;

	// cycles with no beat on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// long sink hold-off used to back the pipeline up into the input
	localparam int SQUEEZE_CYCLES = 150;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;  // comp_first, comp_second, comp_third
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;  // res_first, res_second, res_third
	logic               m_axis_tlast;

	int pending_pixels;
	int mismatch_count;

	// handshake between stimulus and sink: ask for one long hold-off
	bit squeeze_req;
	// source pacing state
	int burst_left;
	bit src_idle_on;
	int src_items;

	rgb_yuv_color_converter_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	ryc_conv_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.pending_pixels (pending_pixels),
		.mismatch_count (mismatch_count)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// components first in the lowest byte
	function automatic logic [TDATA_W-1:0] pack_pixel(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b, input logic [COMP_W-1:0] c);
		return {c, b, a};
	endfunction

	// mostly uniform, with extra weight on the rails and mid scale
	function automatic logic [COMP_W-1:0] pick_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 8'd255;
		if (r == 2)
			return 8'(128 + $urandom_range(0, 6) - 3);
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly short source gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one pixel and hold it until the beat is taken
	task automatic send_pixel(input logic [TDATA_W-1:0] data, input logic last);
		int gap;
		// re-pick idle behavior every 64 pixels so some stretches run back to back
		if (src_items % 64 == 0)
			src_idle_on = ($urandom_range(0, 2) != 0);
		src_items++;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (!src_idle_on) begin
			gap = 0;
		end else begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// direction write, only called with the pipeline empty
	task automatic set_direction(input logic dir);
		cfg_valid <= 1'b1;
		cfg_data <= dir;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait for every converted pixel to come out
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		// let the last accepted beat reach the count before polling it
		@(posedge clk);
		while (pending_pixels != 0) @(posedge clk);
		// pipeline is four deep, then let the clock run on before returning
		repeat (8) @(posedge clk);
	endtask

	// rails, primaries, secondaries, mid gray, near-rail values and alternating bit patterns
	task automatic run_corner_pixels();
		logic [TDATA_W-1:0] corners [11];
		corners[0] = pack_pixel(8'd0, 8'd0, 8'd0);
		corners[1] = pack_pixel(8'd255, 8'd255, 8'd255);
		corners[2] = pack_pixel(8'd255, 8'd0, 8'd0);
		corners[3] = pack_pixel(8'd0, 8'd255, 8'd0);
		corners[4] = pack_pixel(8'd0, 8'd0, 8'd255);
		corners[5] = pack_pixel(8'd128, 8'd128, 8'd128);
		corners[6] = pack_pixel(8'd0, 8'd255, 8'd255);
		corners[7] = pack_pixel(8'd255, 8'd255, 8'd0);
		corners[8] = pack_pixel(8'd255, 8'd0, 8'd255);
		corners[9] = pack_pixel(8'd1, 8'd254, 8'd127);
		corners[10] = pack_pixel(8'd170, 8'd85, 8'd170);
		foreach (corners[i])
			send_pixel(corners[i], (i % 4 == 3) || (i == 10));
	endtask

	task automatic run_random_pixels(input int count, input bit squeeze);
		// back to back burst while the sink holds off, so the input stalls
		if (squeeze) begin
			squeeze_req = 1'b1;
			burst_left = 120;
		end
		repeat (count)
			send_pixel(pack_pixel(pick_comp(), pick_comp(), pick_comp()),
				$urandom_range(0, 7) == 0);
	endtask

	// sink: chunks of always-ready, chunks with random stalls, one long squeeze on request
	initial begin
		int mode;
		int stall;
		int r;
		m_axis_tready = 1'b0;
		stall = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(40, 250)) begin
				@(posedge clk);
				if (squeeze_req) begin
					m_axis_tready <= 1'b0;
					repeat (SQUEEZE_CYCLES) @(posedge clk);
					squeeze_req = 1'b0;
					m_axis_tready <= 1'b1;
				end else if (stall > 0) begin
					m_axis_tready <= 1'b0;
					stall--;
				end else if (mode == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 75) begin
						m_axis_tready <= 1'b1;
					end else begin
						m_axis_tready <= 1'b0;
						stall = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 30);
					end
				end
			end
		end
	end

	// watchdog: any beat on any channel resets the count
	initial begin
		int stuck;
		stuck = 0;
		wait (arst_n);
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		squeeze_req = 1'b0;
		burst_left = 0;
		src_idle_on = 1'b1;
		src_items = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rgb to yuv, corners then random with the long sink hold-off
		set_direction(MODE_RGB2YUV);
		run_corner_pixels();
		run_random_pixels(400, 1'b1);
		drain_pipeline();

		// yuv to rgb, corners then random
		set_direction(MODE_YUV2RGB);
		run_corner_pixels();
		run_random_pixels(400, 1'b0);
		drain_pipeline();

		// switch back and forth once more
		set_direction(MODE_RGB2YUV);
		run_random_pixels(375, 1'b0);
		drain_pipeline();
		set_direction(MODE_YUV2RGB);
		run_random_pixels(375, 1'b0);
		drain_pipeline();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
